/* rtl/value_noise_2d_octaves_top_macros.svh */
// ----------------------------------------------------------------------------
// value_noise_2d_octaves_top_macros
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef VALUE_NOISE_2D_OCTAVES_TOP_MACROS_SVH
`define VALUE_NOISE_2D_OCTAVES_TOP_MACROS_SVH

// same-cycle implication, ignored while in reset
`define VN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("value noise check failed");

// next-cycle implication, ignored while in reset
`define VN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("value noise check failed");

// next-cycle implication that also holds across reset
`define VN_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("value noise check failed");

`endif

/* rtl/vn2o_pkg.sv */
// ----------------------------------------------------------------------------
// vn2o_pkg
// Shared types, widths and slot timing of the octave value-noise block.
// ----------------------------------------------------------------------------
package vn2o_pkg;

  localparam int OCTAVES_DEF    = 5;
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_MAX       = 7;
  localparam int HASH_SHIFT     = 13;
  localparam int HASH_LAT       = 5;

  localparam int CFG_W  = 24;
  localparam int PERS_W = 16;
  localparam int AMP_W  = 17;
  localparam int TOT_W  = 36;
  localparam int ACC_W  = 36;
  localparam int SM_W   = 32;
  localparam int W_W    = 15;
  localparam int B_W    = 46;
  localparam int OUT_W  = 32;

  localparam logic [31:0] HASH_ROW  = 32'd57;
  localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic [AMP_W-1:0] AMP_ONE = 17'h1_0000;

  localparam logic [CFG_W-1:0]  SEED_RST = 24'd1000000;
  localparam logic [PERS_W-1:0] PERS_RST = 16'd6554;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MULT_A  = 2'd0;
  localparam reg_idx_t REG_MULT_B  = 2'd1;
  localparam reg_idx_t REG_ADD_C   = 2'd2;
  localparam reg_idx_t REG_PERSIST = 2'd3;

  // position inside the slot
  typedef logic [3:0] slot_t;
  localparam slot_t SL_SMOOTH = 4'd5;
  localparam slot_t SL_PROD0  = 4'd6;
  localparam slot_t SL_PRODL  = 4'd9;
  localparam slot_t SL_BACC0  = 4'd7;
  localparam slot_t SL_BACCL  = 4'd10;
  localparam slot_t SL_SCALE  = 4'd11;
  localparam slot_t SL_TERM   = 4'd12;
  localparam slot_t SL_HAND   = 4'd13;
  localparam slot_t SL_OUT    = 4'd14;
  localparam slot_t SL_LOAD   = 4'd15;

  // token handed from one octave cell to the next
  typedef struct packed {
    logic                    valid;
    logic [AMP_W-1:0]        amp;
    logic signed [TOT_W-1:0] total;
  } tok_t;

endpackage

/* rtl/vn2o_hash.sv */
// ----------------------------------------------------------------------------
// vn2o_hash
// Pipelined lattice hash, one point per cycle while en is high, result in signed Q2.30.
// ----------------------------------------------------------------------------
module vn2o_hash (
  input  logic                           clk,
  input  logic                           en,
  input  logic [31:0]                    lat_x,
  input  logic [31:0]                    lat_y,
  input  logic [vn2o_pkg::CFG_W-1:0]     mult_a,
  input  logic [vn2o_pkg::CFG_W-1:0]     mult_b,
  input  logic [vn2o_pkg::CFG_W-1:0]     add_c,
  output logic signed [31:0]             h_out
);

  logic [31:0] n_w;
  logic [31:0] nx_w;
  logic [31:0] n0_r, n1_r, n2_r;
  logic [31:0] sq_r, m_r, p_r;
  logic [63:0] sq_w, m_w, p_w;
  logic [31:0] t_w;
  logic signed [31:0] h_r;

  assign n_w  = lat_x + lat_y * vn2o_pkg::HASH_ROW;
  assign nx_w = (n_w << vn2o_pkg::HASH_SHIFT) ^ n_w;
  assign sq_w = n0_r * n0_r;
  assign m_w  = sq_r * {8'b0, mult_a};
  assign p_w  = n2_r * (m_r + {8'b0, mult_b});
  assign t_w  = (p_r + {8'b0, add_c}) & vn2o_pkg::HASH_MASK;

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r <= nx_w;
      sq_r <= sq_w[31:0];
      n1_r <= n0_r;
      m_r  <= m_w[31:0];
      n2_r <= n1_r;
      p_r  <= p_w[31:0];
      h_r  <= vn2o_pkg::ONE_Q30 - $signed(t_w);
    end
  end

  assign h_out = h_r;

endmodule

/* rtl/vn2o_cell.sv */
// ----------------------------------------------------------------------------
// vn2o_cell
// One octave: hashes a 4x4 lattice patch, smooths, interpolates, scales.
// ----------------------------------------------------------------------------
module vn2o_cell #(
  parameter int COORD_BITS = vn2o_pkg::COORD_BITS_DEF,
  parameter int SHIFT      = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            run,
  input  vn2o_pkg::slot_t                 cnt,
  input  logic [vn2o_pkg::CFG_W-1:0]      mult_a,
  input  logic [vn2o_pkg::CFG_W-1:0]      mult_b,
  input  logic [vn2o_pkg::CFG_W-1:0]      add_c,
  input  logic [vn2o_pkg::PERS_W-1:0]     pers,
  input  vn2o_pkg::tok_t                  tok_in,
  input  logic [COORD_BITS-1:0]           x_in,
  input  logic [COORD_BITS-1:0]           y_in,
  output vn2o_pkg::tok_t                  tok_out,
  output logic [COORD_BITS-1:0]           x_out,
  output logic [COORD_BITS-1:0]           y_out
);

  localparam logic [31:0] FMASK = (32'd1 << SHIFT) - 32'd1;

  // hashing side
  vn2o_pkg::tok_t          hv_r;
  logic [COORD_BITS-1:0]   hx_r, hy_r;
  logic [vn2o_pkg::AMP_W+vn2o_pkg::PERS_W-1:0] amp_prod;
  logic [31:0]             x32, y32, cx, cy;
  logic [7:0]              fx_w, fy_w, gx_w, gy_w;
  logic [31:0]             lat_x, lat_y;
  logic signed [31:0]      h_w;
  vn2o_pkg::slot_t         gacc;
  logic signed [vn2o_pkg::ACC_W-1:0] acc_r [4];
  logic signed [vn2o_pkg::ACC_W-1:0] acc_nxt [4];
  logic signed [vn2o_pkg::ACC_W-1:0] sm_w [4];
  logic signed [vn2o_pkg::SM_W-1:0]  sm_r [4];

  // finishing side
  vn2o_pkg::tok_t          fv_r;
  logic [COORD_BITS-1:0]   fx_r, fy_r;
  logic [vn2o_pkg::W_W-1:0] w_r [4];
  logic [1:0]              k;
  logic signed [47:0]      prod_w, prod_r;
  logic signed [vn2o_pkg::B_W-1:0] prod_t, bacc_r;
  logic [39:0]             pl_w, pl_r;
  logic signed [40:0]      ph_w, ph_r;
  logic signed [63:0]      p_w, pr_w;
  logic signed [vn2o_pkg::TOT_W-1:0] term_r;
  vn2o_pkg::tok_t          hand_r;
  logic [COORD_BITS-1:0]   hxo_r, hyo_r;

  assign amp_prod = tok_in.amp * pers;

  assign x32  = 32'(hx_r);
  assign y32  = 32'(hy_r);
  assign cx   = x32 >> SHIFT;
  assign cy   = y32 >> SHIFT;
  assign fx_w = 8'((x32 & FMASK) << (vn2o_pkg::FRAC_MAX - SHIFT));
  assign fy_w = 8'((y32 & FMASK) << (vn2o_pkg::FRAC_MAX - SHIFT));
  assign gx_w = 8'd128 - fx_w;
  assign gy_w = 8'd128 - fy_w;

  // patch point at slot position cnt: column cnt[1:0], row cnt[3:2], from cell -1
  assign lat_x = cx - 32'd1 + 32'(cnt[1:0]);
  assign lat_y = cy - 32'd1 + 32'(cnt[3:2]);

  vn2o_hash u_hash (
    .clk    (clk),
    .en     (run),
    .lat_x  (lat_x),
    .lat_y  (lat_y),
    .mult_a (mult_a),
    .mult_b (mult_b),
    .add_c  (add_c),
    .h_out  (h_w)
  );

  // hash results trail the issue slot by the pipeline depth
  assign gacc = cnt - 4'(vn2o_pkg::HASH_LAT);

  always_comb begin
    logic [1:0] gi, gj;
    logic [1:0] sh;
    logic       hit;
    gi = gacc[1:0];
    gj = gacc[3:2];
    for (int j = 0; j < 4; j++) begin
      // corner j smooths around patch point (1 + dx, 1 + dy)
      hit = (gi >= 2'(j & 1)) && (gi <= 2'((j & 1) + 2))
         && (gj >= 2'(j >> 1)) && (gj <= 2'((j >> 1) + 2));
      sh  = 2'(gi == 2'((j & 1) + 1)) + 2'(gj == 2'((j >> 1) + 1));
      acc_nxt[j] = ((gacc == '0) ? '0 : acc_r[j])
                 + (hit ? (vn2o_pkg::ACC_W'(h_w) <<< sh) : '0);
      sm_w[j] = (acc_r[j] + (acc_r[j][vn2o_pkg::ACC_W-1] ? 36'sd15 : 36'sd0)) >>> 4;
    end
  end

  assign k      = 2'(cnt - vn2o_pkg::SL_PROD0);
  assign prod_w = sm_r[k] * $signed({1'b0, w_r[k]});
  assign prod_t = prod_r[vn2o_pkg::B_W-1:0];
  assign pl_w   = bacc_r[22:0] * fv_r.amp;
  assign ph_w   = $signed(bacc_r[vn2o_pkg::B_W-1:23]) * $signed({1'b0, fv_r.amp});
  assign p_w    = (64'(ph_r) <<< 23) + $signed({24'b0, pl_r});
  // divide by 2^30 toward zero
  assign pr_w   = p_w[63] ? ((p_w + 64'sd1073741823) >>> 30) : (p_w >>> 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r.valid   <= 1'b0;
      fv_r.valid   <= 1'b0;
      hand_r.valid <= 1'b0;
    end else if (run) begin
      for (int j = 0; j < 4; j++) begin
        acc_r[j] <= acc_nxt[j];
      end
      if (cnt == vn2o_pkg::SL_SMOOTH) begin
        for (int j = 0; j < 4; j++) begin
          sm_r[j] <= sm_w[j][vn2o_pkg::SM_W-1:0];
        end
      end
      if (cnt == vn2o_pkg::SL_LOAD) begin
        hv_r.valid <= tok_in.valid;
        fv_r.valid <= hv_r.valid;
        hv_r.amp   <= amp_prod[vn2o_pkg::AMP_W+15:16];
        hv_r.total <= tok_in.total;
        hx_r       <= x_in;
        hy_r       <= y_in;
        fv_r.amp   <= hv_r.amp;
        fv_r.total <= hv_r.total;
        fx_r       <= hx_r;
        fy_r       <= hy_r;
        w_r[0]     <= vn2o_pkg::W_W'(gx_w * gy_w);
        w_r[1]     <= vn2o_pkg::W_W'(fx_w * gy_w);
        w_r[2]     <= vn2o_pkg::W_W'(gx_w * fy_w);
        w_r[3]     <= vn2o_pkg::W_W'(fx_w * fy_w);
      end
      if (cnt >= vn2o_pkg::SL_PROD0 && cnt <= vn2o_pkg::SL_PRODL) begin
        prod_r <= prod_w;
      end
      if (cnt >= vn2o_pkg::SL_BACC0 && cnt <= vn2o_pkg::SL_BACCL) begin
        bacc_r <= ((cnt == vn2o_pkg::SL_BACC0) ? '0 : bacc_r) + prod_t;
      end
      if (cnt == vn2o_pkg::SL_SCALE) begin
        pl_r <= pl_w;
        ph_r <= ph_w;
      end
      if (cnt == vn2o_pkg::SL_TERM) begin
        term_r <= vn2o_pkg::TOT_W'(pr_w);
      end
      if (cnt == vn2o_pkg::SL_HAND) begin
        hand_r.valid <= fv_r.valid;
        hand_r.amp   <= fv_r.amp;
        hand_r.total <= fv_r.total + term_r;
        hxo_r        <= fx_r;
        hyo_r        <= fy_r;
      end
    end
  end

  assign tok_out = hand_r;
  assign x_out   = hxo_r;
  assign y_out   = hyo_r;

endmodule

/* rtl/value_noise_2d_octaves_top.sv */
// ----------------------------------------------------------------------------
// value_noise_2d_octaves_top
// Multi-octave 2D value noise, one signed Q2.30 sample per coordinate pair.
// ----------------------------------------------------------------------------
// The input buffer takes a coordinate pair when free or at the end of a slot;
// each of the OCTAVES cells owns one pipelined lattice hash that covers the
// 4x4 patch of its octave at one point per cycle while the chain runs, and
// that hash unit sets the rate. A sample passes the hashing and then the
// finishing side of each cell. The whole chain holds while a finished beat sits unread.
module value_noise_2d_octaves_top #(
  parameter int OCTAVES    = vn2o_pkg::OCTAVES_DEF,
  parameter int COORD_BITS = vn2o_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_BITS-1:0]              in_x_coord,
  input  logic [COORD_BITS-1:0]              in_y_coord,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vn2o_pkg::OUT_W-1:0]  out_noise_value,
  input  logic                               cfg_we,
  input  vn2o_pkg::reg_idx_t                 cfg_index,
  input  logic [vn2o_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [vn2o_pkg::CFG_W-1:0]  mult_a_r, mult_b_r, add_c_r;
  logic [vn2o_pkg::PERS_W-1:0] pers_r;
  logic                        in_full_r;
  logic [COORD_BITS-1:0]       in_x_r, in_y_r;
  vn2o_pkg::slot_t             cnt_r;
  logic                        run;
  logic                        slot_end;
  logic                        in_take;
  vn2o_pkg::tok_t              tok_c [OCTAVES+1];
  logic [COORD_BITS-1:0]       x_c [OCTAVES+1];
  logic [COORD_BITS-1:0]       y_c [OCTAVES+1];
  logic                        out_valid_r;
  logic signed [vn2o_pkg::OUT_W-1:0] out_r;
  logic signed [vn2o_pkg::TOT_W-1:0] fin_total;
  logic signed [vn2o_pkg::OUT_W-1:0] sat_w;

  assign run      = !(out_valid_r && !out_ready);
  assign slot_end = run && (cnt_r == vn2o_pkg::SL_LOAD);
  assign in_ready = !in_full_r || slot_end;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_a_r <= vn2o_pkg::SEED_RST;
      mult_b_r <= vn2o_pkg::SEED_RST;
      add_c_r  <= vn2o_pkg::SEED_RST;
      pers_r   <= vn2o_pkg::PERS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vn2o_pkg::REG_MULT_A:  mult_a_r <= cfg_wdata;
        vn2o_pkg::REG_MULT_B:  mult_b_r <= cfg_wdata;
        vn2o_pkg::REG_ADD_C:   add_c_r  <= cfg_wdata;
        vn2o_pkg::REG_PERSIST: pers_r   <= cfg_wdata[vn2o_pkg::PERS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (in_take) begin
        in_full_r <= 1'b1;
      end else if (slot_end) begin
        in_full_r <= 1'b0;
      end
      if (run) begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_x_r <= in_x_coord;
      in_y_r <= in_y_coord;
    end
  end

  assign tok_c[0].valid = in_full_r;
  assign tok_c[0].amp   = vn2o_pkg::AMP_ONE;
  assign tok_c[0].total = '0;
  assign x_c[0]         = in_x_r;
  assign y_c[0]         = in_y_r;

  for (genvar i = 0; i < OCTAVES; i++) begin : g_cell
    localparam int SH = (OCTAVES - 1 - i > vn2o_pkg::FRAC_MAX) ?
                        vn2o_pkg::FRAC_MAX : (OCTAVES - 1 - i);
    vn2o_cell #(
      .COORD_BITS (COORD_BITS),
      .SHIFT      (SH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .run     (run),
      .cnt     (cnt_r),
      .mult_a  (mult_a_r),
      .mult_b  (mult_b_r),
      .add_c   (add_c_r),
      .pers    (pers_r),
      .tok_in  (tok_c[i]),
      .x_in    (x_c[i]),
      .y_in    (y_c[i]),
      .tok_out (tok_c[i+1]),
      .x_out   (x_c[i+1]),
      .y_out   (y_c[i+1])
    );
  end

  assign fin_total = tok_c[OCTAVES].total;

  always_comb begin
    if (fin_total > 36'sh0_7FFF_FFFF) begin
      sat_w = 32'sh7FFF_FFFF;
    end else if (fin_total < -36'sh0_8000_0000) begin
      sat_w = 32'sh8000_0000;
    end else begin
      sat_w = fin_total[vn2o_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (run && cnt_r == vn2o_pkg::SL_OUT && tok_c[OCTAVES].valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run && cnt_r == vn2o_pkg::SL_OUT && tok_c[OCTAVES].valid) begin
      out_r <= sat_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_r;

endmodule

/* rtl/vn2o_checker.sv */
// ----------------------------------------------------------------------------
// vn2o_checker
// Port-level checks of the value-noise block, bound to the top level.
// ----------------------------------------------------------------------------
`include "value_noise_2d_octaves_top_macros.svh"

module vn2o_checker #(
  parameter int COORD_BITS = vn2o_pkg::COORD_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [COORD_BITS-1:0]              in_x_coord,
  input logic [COORD_BITS-1:0]              in_y_coord,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [vn2o_pkg::OUT_W-1:0]  out_noise_value
);

  // nothing comes out and the input buffer is free right after reset
  `VN_ASSERT_RST(a_reset_clear, !rst_n, !out_valid && in_ready)

  // a stalled result beat holds
  `VN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_noise_value))

  // a waiting coordinate beat holds
  `VN_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_x_coord) && $stable(in_y_coord))

  // the input side only closes after a beat was taken or while already closed
  `VN_ASSERT_IMP(a_in_closed, !in_ready, $past(in_valid && in_ready) || !$past(in_ready))

endmodule

bind value_noise_2d_octaves_top vn2o_checker #(
  .COORD_BITS (COORD_BITS)
) u_vn2o_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_x_coord      (in_x_coord),
  .in_y_coord      (in_y_coord),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_noise_value (out_noise_value)
);
